/* rtl/segment_intersection_test_core_assert.svh */
// assertion macros shared by the segment intersection checker
// no dependencies; include by bare file name
`ifndef SEGMENT_INTERSECTION_TEST_CORE_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle, masked during reset
`define SIT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("segment intersection check failed");

// antecedent implies consequent in the next cycle, masked during reset
`define SIT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("segment intersection check failed");

// antecedent implies consequent in the next cycle, checked through reset
`define SIT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("segment intersection check failed");

`endif

/* rtl/sit_pkg.sv */
// shared types and constants for the segment intersection test core
// no dependencies
`timescale 1ns / 1ps

package sit_pkg;

   // collinearity threshold register
   localparam int unsigned EPS_WIDTH = 16;
   localparam logic [EPS_WIDTH-1:0] EPS_RESET = 16'd1;

   // orientation codes
   localparam logic [1:0] ORIENT_COLLINEAR = 2'd0;
   localparam logic [1:0] ORIENT_CCW       = 2'd1;
   localparam logic [1:0] ORIENT_CW        = 2'd2;

   // orientation unit latency and whole core latency (accept to strobe)
   localparam int unsigned ORIENT_DEPTH = 4;
   localparam int unsigned PIPE_DEPTH   = ORIENT_DEPTH + 1;

   // result of one orientation unit
   typedef struct packed {
      logic [1:0] code;   // orientation of the triple
      logic       touch;  // collinear and the third point lies in the box
   } sit_orient_result_type;

endpackage

/* rtl/sit_orient.sv */
// four stage orientation unit: differences, products, determinant, classify
// depends on sit_pkg
`timescale 1ns / 1ps

module sit_orient
   import sit_pkg::*;
#(
   parameter int COORD_WIDTH = 20
) (
   input  logic                          clock,
   input  logic signed [COORD_WIDTH-1:0] p_x,
   input  logic signed [COORD_WIDTH-1:0] p_y,
   input  logic signed [COORD_WIDTH-1:0] q_x,
   input  logic signed [COORD_WIDTH-1:0] q_y,
   input  logic signed [COORD_WIDTH-1:0] r_x,
   input  logic signed [COORD_WIDTH-1:0] r_y,
   input  logic        [EPS_WIDTH-1:0]   eps,
   output sit_orient_result_type         result
);

   localparam int DW  = COORD_WIDTH + 1;  // difference width
   localparam int PW  = 2 * DW;           // product width
   localparam int DTW = PW + 1;           // determinant width

   // stage 1: coordinate differences and bounding box test
   logic signed [DW-1:0] dy_qp_in, dx_rq_in, dx_qp_in, dy_rq_in;
   logic signed [DW-1:0] dy_qp_ff, dx_rq_ff, dx_qp_ff, dy_rq_ff;
   logic                 in_box_in, in_box_s1_ff;

   always_comb begin
      dy_qp_in = DW'(q_y) - DW'(p_y);
      dx_rq_in = DW'(r_x) - DW'(q_x);
      dx_qp_in = DW'(q_x) - DW'(p_x);
      dy_rq_in = DW'(r_y) - DW'(q_y);
      // r inside the box spanned by p and q, bounds inclusive
      in_box_in = ((r_x <= p_x) || (r_x <= q_x)) && ((r_x >= p_x) || (r_x >= q_x)) &&
                  ((r_y <= p_y) || (r_y <= q_y)) && ((r_y >= p_y) || (r_y >= q_y));
   end

   always_ff @(posedge clock) begin
      dy_qp_ff     <= dy_qp_in;
      dx_rq_ff     <= dx_rq_in;
      dx_qp_ff     <= dx_qp_in;
      dy_rq_ff     <= dy_rq_in;
      in_box_s1_ff <= in_box_in;
   end

   // stage 2: the two exact products
   logic signed [PW-1:0] prod_a_in, prod_b_in, prod_a_ff, prod_b_ff;
   logic                 in_box_s2_ff;

   always_comb begin
      prod_a_in = PW'(dy_qp_ff) * PW'(dx_rq_ff);
      prod_b_in = PW'(dx_qp_ff) * PW'(dy_rq_ff);
   end

   always_ff @(posedge clock) begin
      prod_a_ff    <= prod_a_in;
      prod_b_ff    <= prod_b_in;
      in_box_s2_ff <= in_box_s1_ff;
   end

   // stage 3: determinant
   logic signed [DTW-1:0] det_in, det_ff;
   logic                  in_box_s3_ff;

   assign det_in = DTW'(prod_a_ff) - DTW'(prod_b_ff);

   always_ff @(posedge clock) begin
      det_ff       <= det_in;
      in_box_s3_ff <= in_box_s2_ff;
   end

   // stage 4: classify against the threshold without taking the magnitude
   logic signed [DTW-1:0] eps_pos, eps_neg;
   logic                  det_neg, collinear;
   sit_orient_result_type result_in, result_ff;

   always_comb begin
      eps_pos   = $signed({{(DTW - EPS_WIDTH){1'b0}}, eps});
      eps_neg   = -eps_pos;
      det_neg   = det_ff[DTW-1];
      collinear = det_neg ? (det_ff > eps_neg) : (det_ff < eps_pos);
      if (collinear) begin
         result_in.code = ORIENT_COLLINEAR;
      end else if (det_neg) begin
         result_in.code = ORIENT_CW;
      end else begin
         result_in.code = ORIENT_CCW;
      end
      result_in.touch = collinear && in_box_s3_ff;
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

/* rtl/segment_intersection_test_core.sv */
// top level of the segment intersection test core
// depends on sit_pkg and sit_orient
`timescale 1ns / 1ps

// Tests two 2-D segments for intersection, touching counted, one segment pair
// per clock. A pair is taken on every edge where start is high and busy is low;
// busy is high only while reset is held. The answer appears on
// rsp_segments_cross with rsp_strobe high for exactly one cycle, in order; the
// receiver cannot hold it off. Each pair passes through four orientation units
// working in parallel (difference, multiply, determinant, classify stages, each
// with two (COORD_WIDTH+1)-bit signed multipliers) and one register that
// combines their verdicts. csr_wr_data loads eps_ff, the collinearity
// threshold in determinant units, reset value 1;
// write it only while no pair is in flight.

module segment_intersection_test_core
   import sit_pkg::*;
#(
   parameter int COORD_WIDTH = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_end_y,
   // response channel
   output logic                          rsp_strobe,
   output logic                          rsp_segments_cross,
   // threshold register
   input  logic                          csr_wr_en,
   input  logic        [EPS_WIDTH-1:0]   csr_wr_data
);

   // threshold register
   logic [EPS_WIDTH-1:0] eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_wr_en) begin
         eps_ff <= csr_wr_data;
      end
   end

   // request transfer
   logic accept;

   assign busy   = reset;
   assign accept = start && !busy;

   // valid bits travel alongside the orientation pipeline
   logic [PIPE_DEPTH-1:0] valid_in, valid_ff;

   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // four orientation units, one per point triple
   sit_orient_result_type orient_a_bs, orient_a_be, orient_b_as, orient_b_ae;

   sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_a_bs (
      .clock  (clock),
      .p_x    (req_seg_a_start_x), .p_y (req_seg_a_start_y),
      .q_x    (req_seg_a_end_x),   .q_y (req_seg_a_end_y),
      .r_x    (req_seg_b_start_x), .r_y (req_seg_b_start_y),
      .eps    (eps_ff),
      .result (orient_a_bs)
   );

   sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_a_be (
      .clock  (clock),
      .p_x    (req_seg_a_start_x), .p_y (req_seg_a_start_y),
      .q_x    (req_seg_a_end_x),   .q_y (req_seg_a_end_y),
      .r_x    (req_seg_b_end_x),   .r_y (req_seg_b_end_y),
      .eps    (eps_ff),
      .result (orient_a_be)
   );

   sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_b_as (
      .clock  (clock),
      .p_x    (req_seg_b_start_x), .p_y (req_seg_b_start_y),
      .q_x    (req_seg_b_end_x),   .q_y (req_seg_b_end_y),
      .r_x    (req_seg_a_start_x), .r_y (req_seg_a_start_y),
      .eps    (eps_ff),
      .result (orient_b_as)
   );

   sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_b_ae (
      .clock  (clock),
      .p_x    (req_seg_b_start_x), .p_y (req_seg_b_start_y),
      .q_x    (req_seg_b_end_x),   .q_y (req_seg_b_end_y),
      .r_x    (req_seg_a_end_x),   .r_y (req_seg_a_end_y),
      .eps    (eps_ff),
      .result (orient_b_ae)
   );

   // combine: proper crossing or a collinear point touching the other segment
   logic cross_in, cross_ff;

   assign cross_in = ((orient_a_bs.code != orient_a_be.code) &&
                      (orient_b_as.code != orient_b_ae.code)) ||
                     orient_a_bs.touch || orient_a_be.touch ||
                     orient_b_as.touch || orient_b_ae.touch;

   always_ff @(posedge clock) begin
      cross_ff <= cross_in;
   end

   assign rsp_strobe         = valid_ff[PIPE_DEPTH-1];
   assign rsp_segments_cross = cross_ff;

endmodule

/* rtl/sit_checker.sv */
// port level checks for the segment intersection test core, bound to the top
// depends on sit_pkg and segment_intersection_test_core_assert.svh
`timescale 1ns / 1ps
`include "segment_intersection_test_core_assert.svh"

module sit_checker
   import sit_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   logic accept;

   assign accept = start && !busy;

   // every request transfer yields a response strobe once it has passed the pipeline
   `SIT_ASSERT_IMP(a_accept_to_strobe, clock, reset, accept, ##PIPE_DEPTH rsp_strobe)

   // no response strobe without a matching earlier request transfer
   `SIT_ASSERT_IMP(a_strobe_has_source, clock, reset, rsp_strobe, $past(accept, PIPE_DEPTH))

   // the core never refuses a request outside reset
   `SIT_ASSERT_IMP(a_never_busy, clock, reset, 1'b1, !busy)

   // reset drops everything in flight
   `SIT_ASSERT_NEXT_ALWAYS(a_reset_flush, clock, reset, !rsp_strobe)

endmodule

bind segment_intersection_test_core sit_checker u_sit_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

/* sim/testbench.sv */
// self-checking testbench for segment_intersection_test_core
// depends on sit_pkg and the core rtl; predicts segments_cross per pair and checks every result
`timescale 1ns / 1ps

module testbench;
   import sit_pkg::*;

   localparam int COORD_W        = 20;
   localparam int COORD_MIN      = -(1 << (COORD_W - 1));
   localparam int COORD_MAX      = (1 << (COORD_W - 1)) - 1;
   localparam int RANDOM_PHASES  = 9;
   localparam int PHASE_PAIRS    = 100;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic signed [COORD_W-1:0] a_sx, a_sy, a_ex, a_ey;
      logic signed [COORD_W-1:0] b_sx, b_sy, b_ex, b_ey;
   } seg_pair_type;

   typedef struct {
      longint x;
      longint y;
   } point_type;

   typedef enum logic [0:0] {
      STEP_PAIR,
      STEP_EPS_WRITE
   } step_kind_type;

   typedef struct {
      step_kind_type        kind;
      seg_pair_type         pair;
      logic [EPS_WIDTH-1:0] eps;
   } stim_step_type;

   // clock, reset and core inputs, all known from time zero
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic signed [COORD_W-1:0] req_seg_a_start_x = '0;
   logic signed [COORD_W-1:0] req_seg_a_start_y = '0;
   logic signed [COORD_W-1:0] req_seg_a_end_x   = '0;
   logic signed [COORD_W-1:0] req_seg_a_end_y   = '0;
   logic signed [COORD_W-1:0] req_seg_b_start_x = '0;
   logic signed [COORD_W-1:0] req_seg_b_start_y = '0;
   logic signed [COORD_W-1:0] req_seg_b_end_x   = '0;
   logic signed [COORD_W-1:0] req_seg_b_end_y   = '0;
   logic                      rsp_strobe;
   logic                      rsp_segments_cross;
   logic                      csr_wr_en   = 1'b0;
   logic [EPS_WIDTH-1:0]      csr_wr_data = '0;

   // testbench state
   stim_step_type        stim_q[$];
   logic                 cross_q[$];
   logic [EPS_WIDTH-1:0] eps_model = EPS_RESET;
   logic                 req_taken = 1'b0;
   int unsigned          gap_left = 0;
   int unsigned          burst_left = 0;
   int unsigned          idle_cycles = 0;
   int unsigned          err_count = 0;

   segment_intersection_test_core #(
      .COORD_WIDTH(COORD_W)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_seg_a_start_x (req_seg_a_start_x),
      .req_seg_a_start_y (req_seg_a_start_y),
      .req_seg_a_end_x   (req_seg_a_end_x),
      .req_seg_a_end_y   (req_seg_a_end_y),
      .req_seg_b_start_x (req_seg_b_start_x),
      .req_seg_b_start_y (req_seg_b_start_y),
      .req_seg_b_end_x   (req_seg_b_end_x),
      .req_seg_b_end_y   (req_seg_b_end_y),
      .rsp_strobe        (rsp_strobe),
      .rsp_segments_cross(rsp_segments_cross),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   // orientation of triple p, q, r; exact determinant, collinear below eps
   function automatic logic [1:0] orientation(point_type p, point_type q, point_type r,
                                              logic [EPS_WIDTH-1:0] eps);
      longint det;
      longint mag;
      det = (q.y - p.y) * (r.x - q.x) - (q.x - p.x) * (r.y - q.y);
      mag = (det < 0) ? -det : det;
      if (mag < longint'(eps))
         return ORIENT_COLLINEAR;
      return (det < 0) ? ORIENT_CW : ORIENT_CCW;
   endfunction

   // q inside the box spanned by p and r, bounds inclusive
   function automatic logic in_bounds(point_type p, point_type q, point_type r);
      longint xmax, xmin, ymax, ymin;
      xmax = (p.x > r.x) ? p.x : r.x;
      xmin = (p.x < r.x) ? p.x : r.x;
      ymax = (p.y > r.y) ? p.y : r.y;
      ymin = (p.y < r.y) ? p.y : r.y;
      return q.x <= xmax && q.x >= xmin && q.y <= ymax && q.y >= ymin;
   endfunction

   function automatic logic crossing_of(seg_pair_type sp, logic [EPS_WIDTH-1:0] eps);
      point_type  as_p, ae_p, bs_p, be_p;
      logic [1:0] o1, o2, o3, o4;
      as_p = '{longint'(sp.a_sx), longint'(sp.a_sy)};
      ae_p = '{longint'(sp.a_ex), longint'(sp.a_ey)};
      bs_p = '{longint'(sp.b_sx), longint'(sp.b_sy)};
      be_p = '{longint'(sp.b_ex), longint'(sp.b_ey)};
      o1 = orientation(as_p, ae_p, bs_p, eps);
      o2 = orientation(as_p, ae_p, be_p, eps);
      o3 = orientation(bs_p, be_p, as_p, eps);
      o4 = orientation(bs_p, be_p, ae_p, eps);
      return (o1 != o2 && o3 != o4)
         || (o1 == ORIENT_COLLINEAR && in_bounds(as_p, bs_p, ae_p))
         || (o2 == ORIENT_COLLINEAR && in_bounds(as_p, be_p, ae_p))
         || (o3 == ORIENT_COLLINEAR && in_bounds(bs_p, as_p, be_p))
         || (o4 == ORIENT_COLLINEAR && in_bounds(bs_p, ae_p, be_p));
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic seg_pair_type make_pair(int ax, int ay, int bx, int by,
                                              int cx, int cy, int dx, int dy);
      seg_pair_type sp;
      sp.a_sx = COORD_W'(ax);
      sp.a_sy = COORD_W'(ay);
      sp.a_ex = COORD_W'(bx);
      sp.a_ey = COORD_W'(by);
      sp.b_sx = COORD_W'(cx);
      sp.b_sy = COORD_W'(cy);
      sp.b_ex = COORD_W'(dx);
      sp.b_ey = COORD_W'(dy);
      return sp;
   endfunction

   function automatic void add_pair(seg_pair_type sp);
      stim_q.push_back('{STEP_PAIR, sp, '0});
   endfunction

   function automatic void add_eps(logic [EPS_WIDTH-1:0] value);
      stim_q.push_back('{STEP_EPS_WRITE, make_pair(0, 0, 0, 0, 0, 0, 0, 0), value});
   endfunction

   function automatic int span_int(int unsigned span);
      return int'($urandom_range(0, 2 * span)) - int'(span);
   endfunction

   // random pair; mostly shapes where ties, touches and collinearity are likely
   function automatic seg_pair_type random_pair();
      int          x [4];
      int          y [4];
      int          ext [7];
      int          px, py, dx, dy, j;
      int unsigned pick, lim;
      ext = '{COORD_MIN, COORD_MAX, 0, -1, 1, COORD_MIN + 1, COORD_MAX - 1};
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         // full range, every bit toggles
         for (int i = 0; i < 4; i++) begin
            x[i] = int'($urandom);
            y[i] = int'($urandom);
         end
      end else if (pick < 30) begin
         // corners and neighbors of zero
         for (int i = 0; i < 4; i++) begin
            x[i] = ext[$urandom_range(0, 6)];
            y[i] = ext[$urandom_range(0, 6)];
         end
      end else if (pick < 50) begin
         // tight or mid-size box
         lim = ($urandom_range(0, 1) != 0) ? 16 : 600;
         for (int i = 0; i < 4; i++) begin
            x[i] = span_int(lim);
            y[i] = span_int(lim);
         end
      end else if (pick < 85) begin
         // points on one line, sometimes nudged off it
         lim = ($urandom_range(0, 1) != 0) ? 3 : 60;
         px  = span_int(2000);
         py  = span_int(2000);
         dx  = span_int(lim);
         dy  = span_int(lim);
         for (int i = 0; i < 4; i++) begin
            j = span_int(8);
            x[i] = px + j * dx;
            y[i] = py + j * dy;
         end
         if (pick >= 70) begin
            j = $urandom_range(0, 3);
            x[j] += span_int(1);
            y[j] += span_int(1);
         end
      end else begin
         // shared endpoints and degenerate segments
         for (int i = 0; i < 4; i++) begin
            x[i] = span_int(300);
            y[i] = span_int(300);
         end
         case ($urandom_range(0, 3))
            0: begin
               x[2] = x[1];
               y[2] = y[1];
            end
            1: begin
               x[1] = x[0];
               y[1] = y[0];
            end
            2: begin
               x[2] = x[1];
               y[2] = y[1];
               x[3] = x[0];
               y[3] = y[0];
            end
            default: begin
               x[2] = x[0];
               y[2] = y[0];
            end
         endcase
      end
      return make_pair(x[0], y[0], x[1], y[1], x[2], y[2], x[3], y[3]);
   endfunction

   // ---------------------------------------------------------------- driver

   // one transfer or one register write per step, changed on the falling edge
   always @(negedge clock) begin
      logic next_start;
      logic next_wr;
      if (reset) begin
         start     <= 1'b0;
         csr_wr_en <= 1'b0;
      end else begin
         next_start = start && !req_taken;
         next_wr    = 1'b0;
         if (!next_start) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (stim_q.size() != 0) begin
               if (stim_q[0].kind == STEP_PAIR) begin
                  req_seg_a_start_x <= stim_q[0].pair.a_sx;
                  req_seg_a_start_y <= stim_q[0].pair.a_sy;
                  req_seg_a_end_x   <= stim_q[0].pair.a_ex;
                  req_seg_a_end_y   <= stim_q[0].pair.a_ey;
                  req_seg_b_start_x <= stim_q[0].pair.b_sx;
                  req_seg_b_start_y <= stim_q[0].pair.b_sy;
                  req_seg_b_end_x   <= stim_q[0].pair.b_ex;
                  req_seg_b_end_y   <= stim_q[0].pair.b_ey;
                  next_start = 1'b1;
                  void'(stim_q.pop_front());
                  // gap after this pair: mostly none, some short, a few long
                  if (burst_left != 0) begin
                     burst_left--;
                     gap_left = 0;
                  end else if ($urandom_range(0, 99) == 0) begin
                     burst_left = 60;
                     gap_left   = 0;
                  end else begin
                     case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: gap_left = 0;
                        13, 14, 15, 16, 17, 18: gap_left = $urandom_range(1, 3);
                        default: gap_left = $urandom_range(8, 40);
                     endcase
                  end
               end else if (cross_q.size() == 0) begin
                  // register write only once every result is back
                  csr_wr_data <= stim_q[0].eps;
                  next_wr = 1'b1;
                  void'(stim_q.pop_front());
               end
            end
         end
         start     <= next_start;
         csr_wr_en <= next_wr;
      end
   end

   // ---------------------------------------------------------------- monitor

   // register writes, accepted pairs and results, sampled on the rising edge
   always @(posedge clock) begin
      seg_pair_type taken_pair;
      logic         exp_cross;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (csr_wr_en)
            eps_model = csr_wr_data;
         if (start && !busy) begin
            taken_pair.a_sx = req_seg_a_start_x;
            taken_pair.a_sy = req_seg_a_start_y;
            taken_pair.a_ex = req_seg_a_end_x;
            taken_pair.a_ey = req_seg_a_end_y;
            taken_pair.b_sx = req_seg_b_start_x;
            taken_pair.b_sy = req_seg_b_start_y;
            taken_pair.b_ex = req_seg_b_end_x;
            taken_pair.b_ey = req_seg_b_end_y;
            cross_q.push_back(crossing_of(taken_pair, eps_model));
         end
         if (rsp_strobe) begin
            if (cross_q.size() == 0) begin
               $display("%0t unexpected result: segments_cross expected none actual %0b",
                        $time, rsp_segments_cross);
               err_count++;
            end else begin
               exp_cross = cross_q.pop_front();
               if (rsp_segments_cross !== exp_cross) begin
                  $display("%0t mismatch segments_cross: expected %0b actual %0b",
                           $time, exp_cross, rsp_segments_cross);
                  err_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no transfer of any kind
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe || csr_wr_en)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
            $display("status: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      logic [EPS_WIDTH-1:0] phase_eps [RANDOM_PHASES];

      // directed pairs at the reset threshold; 256 is 1.0 in Q11.8
      add_pair(make_pair(-256, -256, 256, 256, -256, 256, 256, -256));  // proper cross
      add_pair(make_pair(0, 0, 512, 0, 0, 256, 512, 256));              // parallel
      add_pair(make_pair(0, 0, 256, 256, 256, 256, 512, 0));            // shared endpoint
      add_pair(make_pair(0, 0, 512, 0, 256, 0, 768, 0));                // collinear overlap
      add_pair(make_pair(0, 0, 256, 0, 512, 0, 768, 0));                // collinear apart
      add_pair(make_pair(0, 0, 256, 0, 256, 0, 512, 0));                // collinear touch
      add_pair(make_pair(0, 0, 512, 0, 256, 0, 256, 512));              // t junction
      add_pair(make_pair(0, 0, 512, 0, 256, 1, 256, 512));              // near miss
      add_pair(make_pair(128, 128, 128, 128, 0, 0, 256, 256));          // point on segment
      add_pair(make_pair(128, 129, 128, 129, 0, 0, 256, 256));          // point off segment
      add_pair(make_pair(77, -33, 77, -33, 77, -33, 77, -33));          // same point twice
      add_pair(make_pair(5, 5, 5, 5, 6, 6, 6, 6));                      // two distinct points
      add_pair(make_pair(0, 0, 2, 0, 1, 1, 1, 3));                      // tiny determinant
      add_pair(make_pair(0, 0, 2, 1, 1, 0, 3, 1));                      // determinant of one
      add_pair(make_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                         COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));  // full-range cross
      add_pair(make_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                         COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      add_pair(make_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                         COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      add_pair(make_pair(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                         COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      add_pair(make_pair(COORD_MIN, 0, COORD_MAX, 0, 0, 0, COORD_MAX, 0));
      add_pair(make_pair(-1, -1, 1, 1, -1, 1, 1, -1));
      add_pair(make_pair(0, 0, 256, 512, 256, 512, 0, 0));              // same segment reversed
      add_pair(make_pair(0, 0, 256, 0, 0, 0, 0, 256));                  // shared start

      // random phases, each behind a threshold write; zero and full scale included
      phase_eps = '{16'd0, 16'hFFFF, 16'd2, 16'($urandom), 16'd3, EPS_RESET,
                    16'($urandom_range(4, 600)), 16'hFFFF, 16'd0};
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         add_eps(phase_eps[ph]);
         for (int n = 0; n < PHASE_PAIRS; n++)
            add_pair(random_pair());
      end

      // reset held from time zero, released on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain: all pairs taken, all results back, then a further wait before the verdict
      while (stim_q.size() != 0 || start || cross_q.size() != 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 3) @(posedge clock);

      if (err_count == 0 && cross_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
